// File: rtl/permutation_swap_crossover_assert.svh
// Assertion macros used by the port checker of the crossover block.
`ifndef PERMUTATION_SWAP_CROSSOVER_ASSERT_SVH
`define PERMUTATION_SWAP_CROSSOVER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PSC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("psc port check failed");

// Consequent must hold in the cycle after the antecedent.
`define PSC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("psc port check failed");

`endif

// File: rtl/psc_pkg.sv
package psc_pkg;

   localparam int CITIES    = 64;
   localparam int CITY_W    = 7;
   localparam int POS_W     = $clog2(CITIES);
   localparam int CNT_W     = $clog2(CITIES + 1);
   localparam int MAP_DEPTH = CITIES + 1;
   localparam int MAP_AW    = $clog2(MAP_DEPTH);

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_NEXT,
      ST_RD_SEC,
      ST_RD_MAP,
      ST_RD_CHILD,
      ST_WR_DISP,
      ST_WR_CITY,
      ST_EMIT_RD,
      ST_EMIT_LD,
      ST_EMIT_HOLD
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // input transaction accepted
      logic rd_sec;     // read second tour at current index
      logic rd_map;     // read position map for the second-parent city
      logic rd_child;   // read child at mapped position and at current index
      logic wr_disp;    // move displaced city to mapped position
      logic wr_city;    // place second-parent city at current index
      logic set_err;    // flag a missing city
      logic step;       // advance the range index
      logic emit_rd;    // read child at emit counter
      logic emit_ld;    // load the output register
      logic emit_next;  // output transaction taken
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic range_more; // index still below range end
      logic city_bad;   // second-parent city id above the city count
      logic pos_bad;    // mapped position outside the loaded tour
      logic mismatch;   // child entry at mapped position holds another city
      logic emit_last;  // output register holds the final child position
   } sts_type;

endpackage

// File: rtl/psc_ctrl.sv
module psc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tlast,
   input  logic               rsp_tready,
   input  psc_pkg::sts_type   sts,
   output logic               req_tready,
   output logic               rsp_tvalid,
   output psc_pkg::cmd_type   cmd
);

   psc_pkg::state_type state_ff;
   psc_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psc_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         psc_pkg::ST_LOAD: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (req_tlast) begin
                  state_in = psc_pkg::ST_NEXT;
               end
            end
         end
         psc_pkg::ST_NEXT: begin
            if (sts.range_more) begin
               state_in = psc_pkg::ST_RD_SEC;
            end else begin
               state_in = psc_pkg::ST_EMIT_RD;
            end
         end
         psc_pkg::ST_RD_SEC: begin
            cmd.rd_sec = 1'b1;
            state_in   = psc_pkg::ST_RD_MAP;
         end
         psc_pkg::ST_RD_MAP: begin
            if (sts.city_bad) begin
               cmd.set_err = 1'b1;
               cmd.step    = 1'b1;
               state_in    = psc_pkg::ST_NEXT;
            end else begin
               cmd.rd_map = 1'b1;
               state_in   = psc_pkg::ST_RD_CHILD;
            end
         end
         psc_pkg::ST_RD_CHILD: begin
            if (sts.pos_bad) begin
               cmd.set_err = 1'b1;
               cmd.step    = 1'b1;
               state_in    = psc_pkg::ST_NEXT;
            end else begin
               cmd.rd_child = 1'b1;
               state_in     = psc_pkg::ST_WR_DISP;
            end
         end
         psc_pkg::ST_WR_DISP: begin
            if (sts.mismatch) begin
               cmd.set_err = 1'b1;
               cmd.step    = 1'b1;
               state_in    = psc_pkg::ST_NEXT;
            end else begin
               cmd.wr_disp = 1'b1;
               state_in    = psc_pkg::ST_WR_CITY;
            end
         end
         psc_pkg::ST_WR_CITY: begin
            cmd.wr_city = 1'b1;
            cmd.step    = 1'b1;
            state_in    = psc_pkg::ST_NEXT;
         end
         psc_pkg::ST_EMIT_RD: begin
            cmd.emit_rd = 1'b1;
            state_in    = psc_pkg::ST_EMIT_LD;
         end
         psc_pkg::ST_EMIT_LD: begin
            cmd.emit_ld = 1'b1;
            state_in    = psc_pkg::ST_EMIT_HOLD;
         end
         psc_pkg::ST_EMIT_HOLD: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               cmd.emit_next = 1'b1;
               if (sts.emit_last) begin
                  state_in = psc_pkg::ST_LOAD;
               end else begin
                  state_in = psc_pkg::ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = psc_pkg::ST_LOAD;
         end
      endcase
   end

endmodule

// File: rtl/psc_dp.sv
module psc_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  psc_pkg::cmd_type             cmd,
   input  logic [psc_pkg::CITY_W-1:0]   first_parent_city,
   input  logic [psc_pkg::CITY_W-1:0]   second_parent_city,
   input  logic [psc_pkg::CITY_W-1:0]   copy_from,
   input  logic [psc_pkg::CITY_W-1:0]   copy_to,
   input  logic                         last_element,
   output logic [psc_pkg::CITY_W-1:0]   child_city,
   output logic                         last_of_tour,
   output logic                         missing_city,
   output psc_pkg::sts_type             sts
);

   // tour stores
   logic [psc_pkg::CITY_W-1:0] child_mem [psc_pkg::CITIES];
   logic [psc_pkg::CITY_W-1:0] sec_mem   [psc_pkg::CITIES];
   logic [psc_pkg::POS_W-1:0]  map_mem   [psc_pkg::MAP_DEPTH];

   // registered read data
   logic [psc_pkg::CITY_W-1:0] child_a_ff;
   logic [psc_pkg::CITY_W-1:0] child_b_ff;
   logic [psc_pkg::CITY_W-1:0] sec_ff;
   logic [psc_pkg::POS_W-1:0]  map_ff;

   // counters and range
   logic [psc_pkg::CNT_W-1:0]  loaded_ff;
   logic [psc_pkg::CNT_W-1:0]  emit_ff;
   logic [psc_pkg::CITY_W-1:0] idx_ff;
   logic [psc_pkg::CNT_W-1:0]  stop_ff;
   logic                       err_ff;

   // output register
   logic [psc_pkg::CITY_W-1:0] rsp_city_ff;
   logic                       rsp_last_ff;
   logic                       rsp_err_ff;

   logic                       room;
   logic [psc_pkg::CNT_W-1:0]  len_new;
   logic [psc_pkg::CNT_W-1:0]  stop_in;
   logic [psc_pkg::POS_W-1:0]  idx_pos;
   logic [psc_pkg::POS_W-1:0]  load_pos;

   logic                       child_we;
   logic [psc_pkg::POS_W-1:0]  child_wa;
   logic [psc_pkg::CITY_W-1:0] child_wd;
   logic [psc_pkg::POS_W-1:0]  child_ra;
   logic                       map_we;
   logic [psc_pkg::MAP_AW-1:0] map_wa;
   logic [psc_pkg::POS_W-1:0]  map_wd;

   assign room     = loaded_ff < psc_pkg::CNT_W'(psc_pkg::CITIES);
   assign len_new  = room ? psc_pkg::CNT_W'(loaded_ff + psc_pkg::CNT_W'(1)) : loaded_ff;
   assign idx_pos  = idx_ff[psc_pkg::POS_W-1:0];
   assign load_pos = loaded_ff[psc_pkg::POS_W-1:0];

   // saturate range end at the tour length
   always_comb begin
      if (copy_to > psc_pkg::CITY_W'(len_new)) begin
         stop_in = len_new;
      end else begin
         stop_in = copy_to[psc_pkg::CNT_W-1:0];
      end
   end

   // child write port
   always_comb begin
      child_we = 1'b0;
      child_wa = load_pos;
      child_wd = first_parent_city;
      if (cmd.load && room) begin
         child_we = 1'b1;
      end else if (cmd.wr_disp) begin
         child_we = 1'b1;
         child_wa = map_ff;
         child_wd = child_b_ff;
      end else if (cmd.wr_city) begin
         child_we = 1'b1;
         child_wa = idx_pos;
         child_wd = sec_ff;
      end
   end

   // map write port; city ids above the city count never enter the map
   always_comb begin
      map_we = 1'b0;
      map_wa = first_parent_city[psc_pkg::MAP_AW-1:0];
      map_wd = load_pos;
      if (cmd.load && room) begin
         map_we = first_parent_city <= psc_pkg::CITY_W'(psc_pkg::CITIES);
      end else if (cmd.wr_disp) begin
         map_we = child_b_ff <= psc_pkg::CITY_W'(psc_pkg::CITIES);
         map_wa = child_b_ff[psc_pkg::MAP_AW-1:0];
         map_wd = map_ff;
      end else if (cmd.wr_city) begin
         map_we = 1'b1;
         map_wa = sec_ff[psc_pkg::MAP_AW-1:0];
         map_wd = idx_pos;
      end
   end

   assign child_ra = cmd.emit_rd ? emit_ff[psc_pkg::POS_W-1:0] : map_ff;

   always_ff @(posedge clock) begin
      if (child_we) begin
         child_mem[child_wa] <= child_wd;
      end
      if (cmd.rd_child || cmd.emit_rd) begin
         child_a_ff <= child_mem[child_ra];
      end
      if (cmd.rd_child) begin
         child_b_ff <= child_mem[idx_pos];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && room) begin
         sec_mem[load_pos] <= second_parent_city;
      end
      if (cmd.rd_sec) begin
         sec_ff <= sec_mem[idx_pos];
      end
   end

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_wa] <= map_wd;
      end
      if (cmd.rd_map) begin
         map_ff <= map_mem[sec_ff[psc_pkg::MAP_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= '0;
         emit_ff   <= '0;
         err_ff    <= 1'b0;
      end else begin
         if (cmd.load && room) begin
            loaded_ff <= len_new;
         end
         if (cmd.set_err) begin
            err_ff <= 1'b1;
         end
         if (cmd.emit_next) begin
            if (rsp_last_ff) begin
               loaded_ff <= '0;
               emit_ff   <= '0;
               err_ff    <= 1'b0;
            end else begin
               emit_ff <= psc_pkg::CNT_W'(emit_ff + psc_pkg::CNT_W'(1));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && last_element) begin
         idx_ff  <= copy_from;
         stop_ff <= stop_in;
      end else if (cmd.step) begin
         idx_ff <= psc_pkg::CITY_W'(idx_ff + psc_pkg::CITY_W'(1));
      end
      if (cmd.emit_ld) begin
         rsp_city_ff <= child_a_ff;
         rsp_last_ff <= psc_pkg::CNT_W'(emit_ff + psc_pkg::CNT_W'(1)) == loaded_ff;
         rsp_err_ff  <= err_ff;
      end
   end

   assign sts.range_more = idx_ff < psc_pkg::CITY_W'(stop_ff);
   assign sts.city_bad   = sec_ff > psc_pkg::CITY_W'(psc_pkg::CITIES);
   assign sts.pos_bad    = psc_pkg::CNT_W'(map_ff) >= loaded_ff;
   assign sts.mismatch   = child_a_ff != sec_ff;
   assign sts.emit_last  = rsp_last_ff;

   assign child_city   = rsp_city_ff;
   assign last_of_tour = rsp_last_ff;
   assign missing_city = rsp_err_ff;

endmodule

// File: rtl/permutation_swap_crossover.sv
// Partially mapped crossover of two city tours, done by swaps. Send one input
// transaction per tour position (first-parent city, second-parent city); the
// transaction with tlast closes the tour and carries the half-open copy range
// [copy_from, copy_to). The child starts as the first parent; for each index
// in the range the child entry holding the second parent's city there is
// swapped into that index, found through a position map. The child tour then
// comes out one position per output transaction, tlast on the final one and
// tuser set on every position if some second-parent city was absent from the
// child. Each index of the range reads the second tour, the map and the
// child, then writes the displaced and the second-parent city; a skipped
// index stops at the check that fails. The steps are apart as the child
// store and the map each have a single write port and every read is
// registered. One tour is handled at a time: input is taken only while
// loading. The position count stays at 64 and positions beyond it are
// dropped; a dropped tlast transaction still starts the crossover.
module permutation_swap_crossover (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   // [6:0] first_parent_city, [13:7] second_parent_city,
   // [20:14] copy_from, [27:21] copy_to, [31:28] zero
   input  logic [31:0] req_tdata,
   input  logic        req_tlast,   // last_element

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [6:0] child_city, [7] zero
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast,   // last_of_tour
   output logic        rsp_tuser    // [0] missing_city
);

   psc_pkg::cmd_type            cmd;
   psc_pkg::sts_type            sts;
   logic [psc_pkg::CITY_W-1:0]  child_city;

   // sequence load, swap and emit
   psc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .cmd        (cmd)
   );

   // tour stores, position map, counters and output register
   psc_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .first_parent_city  (req_tdata[6:0]),
      .second_parent_city (req_tdata[13:7]),
      .copy_from          (req_tdata[20:14]),
      .copy_to            (req_tdata[27:21]),
      .last_element       (req_tlast),
      .child_city         (child_city),
      .last_of_tour       (rsp_tlast),
      .missing_city       (rsp_tuser),
      .sts                (sts)
   );

   // pad the child city up to a whole byte
   assign rsp_tdata = {1'b0, child_city};

endmodule

// File: rtl/psc_checker.sv
`include "permutation_swap_crossover_assert.svh"

module psc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);

   logic       rsp_take;
   logic       rsp_stall;
   logic [9:0] rsp_word;

   assign rsp_take  = rsp_tvalid && rsp_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_word  = {rsp_tuser, rsp_tlast, rsp_tdata};

   // a stalled result holds its payload
   `PSC_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_word))

   // loading and emitting never overlap
   `PSC_ASSERT_SAME(a_no_overlap, req_tready, !rsp_tvalid)

   // the final child position returns the block to loading
   `PSC_ASSERT_NEXT(a_tour_end, rsp_take && rsp_tlast, req_tready && !rsp_tvalid)

   // inside a tour the block keeps emitting and takes no input
   `PSC_ASSERT_NEXT(a_tour_mid, rsp_take && !rsp_tlast, !req_tready)

endmodule

bind permutation_swap_crossover psc_checker u_psc_checker (.*);
